// ===== hw/rtl/box_downsample_average_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BOX_DOWNSAMPLE_AVERAGE_UNIT_ASSERT_SVH
`define BOX_DOWNSAMPLE_AVERAGE_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define BDSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define BDSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, reset included.
`define BDSA_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bdsa_pkg.sv =====
package bdsa_pkg;

  // Field and register widths
  localparam int PIX_W      = 8;
  localparam int AVG_W      = 8;
  localparam int FAC_W      = 4;
  localparam int DIM_W      = 12;
  localparam int CFG_IDX_W  = 2;

  // Geometry limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_FACTOR = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = DIM_W;
  localparam int SUB_W      = $clog2(MAX_FACTOR);
  localparam int POS_W      = ROW_W + FAC_W + 1;

  // Block sum: up to MAX_FACTOR squared pixels of 255
  localparam int SUM_W      = 14;

  // Reciprocal divide by factor squared
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int AVG_MAX     = 254;

  // Result queue
  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = OFIFO_AW + 1;
  localparam int CREDIT_W    = OFIFO_CW + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR    = 2'd0,
    CFG_IN_WIDTH  = 2'd1,
    CFG_IN_HEIGHT = 2'd2
  } cfg_idx_t;

  // Read-modify-write request for one pixel
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first;
    logic [PIX_W-1:0] pixel;
    logic [FAC_W-1:0] fac;
    logic             emit;
    logic             row_end;
  } acc_req_t;

  // Finished block on its way to the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [FAC_W-1:0] fac;
    logic             row_end;
  } blk_t;

  // One result word
  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             row_end;
  } res_t;

  // ceil(2^RECIP_SHIFT / f^2), exact floor for every sum below 2^SUM_W
  function automatic logic [RECIP_W-1:0] recip_of(input logic [FAC_W-1:0] f);
    logic [RECIP_W-1:0] r;
    case (f)
      4'd1:    r = RECIP_W'(1048576);
      4'd2:    r = RECIP_W'(262144);
      4'd3:    r = RECIP_W'(116509);
      4'd4:    r = RECIP_W'(65536);
      4'd5:    r = RECIP_W'(41944);
      4'd6:    r = RECIP_W'(29128);
      4'd7:    r = RECIP_W'(21400);
      4'd8:    r = RECIP_W'(16384);
      default: r = RECIP_W'(1048576);
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/box_downsample_average_unit.sv =====
// Box-filter downsampler for a raster stream of 8-bit pixels.
// Input channel: in_valid / in_stall / in_pixel, one word per source pixel in
// raster order. Output channel: out_valid / out_stall / out_average /
// out_row_end, one word per finished factor-by-factor block, in raster order
// of the reduced image; out_row_end marks the last block of a block row.
// Configuration: cfg_we / cfg_index / cfg_data write factor (0), in_width (1)
// and in_height (2); write them only while no word is in flight.
// A block's word passes the request, block and product registers and the
// result queue before it shows on out_valid. Throughput: one pixel per cycle
// while in_stall is low, set by the read-modify-write of the column sum
// store (registered read, with the previous write forwarded).
// The reciprocal multiply sits in its own stage, followed by the clamp.
// A result queue of 8 words parts the two sides; in_stall rises when the
// queue plus the blocks still in the pipeline would fill it, so a stalled
// receiver backs up the source after a few words.
// Reset clears the raster position, the pipeline and the queue and sets
// factor 1, width 2048, height 2048; the column sums are not cleared, each
// is overwritten at the first pixel of its block.
module box_downsample_average_unit import bdsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [AVG_W-1:0]     out_average,
  output logic                 out_row_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [FAC_W-1:0]    factor_r;
  logic [DIM_W-1:0]    in_width_r;
  logic [DIM_W-1:0]    in_height_r;
  logic                accept;
  acc_req_t            req;
  logic                s1_emit;
  logic                blk_v;
  blk_t                blk;
  logic                res_v;
  res_t                res;
  res_t                head;
  logic [OFIFO_CW-1:0] fifo_cnt;
  logic [CREDIT_W-1:0] credit_used;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r    <= FAC_W'(1);
      in_width_r  <= DIM_W'(2048);
      in_height_r <= DIM_W'(2048);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FACTOR:    factor_r    <= cfg_data[FAC_W-1:0];
        CFG_IN_WIDTH:  in_width_r  <= cfg_data;
        CFG_IN_HEIGHT: in_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stall when queued plus in-flight results leave no free slot
  assign credit_used = CREDIT_W'(fifo_cnt) + CREDIT_W'(s1_emit) + CREDIT_W'(blk_v)
                     + CREDIT_W'(res_v);
  assign in_stall    = credit_used >= CREDIT_W'(OFIFO_DEPTH);
  assign accept      = in_valid && !in_stall;

  bdsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .factor    (factor_r),
    .in_width  (in_width_r),
    .in_height (in_height_r),
    .accept    (accept),
    .pixel     (in_pixel),
    .req       (req)
  );

  bdsa_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .req     (req),
    .s1_emit (s1_emit),
    .blk_v   (blk_v),
    .blk     (blk)
  );

  bdsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .blk_v (blk_v),
    .blk   (blk),
    .res_v (res_v),
    .res   (res)
  );

  bdsa_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_v),
    .push_data (res),
    .pop       (out_valid && !out_stall),
    .not_empty (out_valid),
    .head      (head),
    .count     (fifo_cnt)
  );

  assign out_average = head.average;
  assign out_row_end = head.row_end;

endmodule

// ===== hw/rtl/bdsa_ram.sv =====
module bdsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bdsa_ctrl.sv =====
module bdsa_ctrl import bdsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [FAC_W-1:0] factor,
  input  logic [DIM_W-1:0] in_width,
  input  logic [DIM_W-1:0] in_height,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel,
  output acc_req_t         req
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SUB_W-1:0] subc_r, subc_nxt;
  logic [SUB_W-1:0] subr_r, subr_nxt;

  logic [FAC_W-1:0] f_eff;
  logic [FAC_W-1:0] f_m1;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [POS_W-1:0] x;
  logic [POS_W-1:0] y;
  logic             last_col;
  logic             last_row;
  logic             at_row_end;
  logic             at_frame_end;

  // Clamp the configuration to usable values
  always_comb begin
    if (factor == '0) begin
      f_eff = FAC_W'(1);
    end else if (factor > FAC_W'(MAX_FACTOR)) begin
      f_eff = FAC_W'(MAX_FACTOR);
    end else begin
      f_eff = factor;
    end
    if (in_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (in_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = in_width;
    end
    h_eff = (in_height == '0) ? DIM_W'(1) : in_height;
  end

  // Pixel position and block boundaries
  assign f_m1         = f_eff - FAC_W'(1);
  assign x            = POS_W'(col_r) * POS_W'(f_eff) + POS_W'(subc_r);
  assign y            = POS_W'(row_r) * POS_W'(f_eff) + POS_W'(subr_r);
  assign last_col     = FAC_W'(subc_r) >= f_m1;
  assign last_row     = FAC_W'(subr_r) >= f_m1;
  assign at_row_end   = x >= POS_W'(w_eff - DIM_W'(1));
  assign at_frame_end = y >= POS_W'(h_eff - DIM_W'(1));

  // Build the request for the line store
  always_comb begin
    req.col     = col_r;
    req.first   = (subc_r == '0) && (subr_r == '0);
    req.pixel   = pixel;
    req.fac     = f_eff;
    req.emit    = last_col && last_row;
    req.row_end = (x + POS_W'(f_eff)) >= POS_W'(w_eff);
  end

  // Advance the raster position on each accepted word
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    subc_nxt = subc_r;
    subr_nxt = subr_r;
    if (accept) begin
      if (at_row_end) begin
        subc_nxt = '0;
        col_nxt  = '0;
        if (at_frame_end) begin
          subr_nxt = '0;
          row_nxt  = '0;
        end else if (last_row) begin
          subr_nxt = '0;
          row_nxt  = row_r + ROW_W'(1);
        end else begin
          subr_nxt = subr_r + SUB_W'(1);
        end
      end else if (last_col) begin
        subc_nxt = '0;
        col_nxt  = col_r + COL_W'(1);
      end else begin
        subc_nxt = subc_r + SUB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      subc_r <= '0;
      subr_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      subc_r <= subc_nxt;
      subr_r <= subr_nxt;
    end
  end

endmodule

// ===== hw/rtl/bdsa_accum.sv =====
module bdsa_accum import bdsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  acc_req_t req,
  output logic     s1_emit,
  output logic     blk_v,
  output blk_t     blk
);

  acc_req_t         s1_r;
  logic             s1_v_r;
  logic [SUM_W-1:0] rd_sum;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] sum_new;
  logic             wb_v_r;
  logic [COL_W-1:0] wb_col_r;
  logic [SUM_W-1:0] wb_sum_r;
  logic             blk_v_r;
  blk_t             blk_r;

  // Column sum line store
  bdsa_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_r.col),
    .wdata (sum_new),
    .raddr (req.col),
    .rdata (rd_sum)
  );

  // Forward the write of the previous cycle, which the read missed
  assign base    = (wb_v_r && (wb_col_r == s1_r.col)) ? wb_sum_r : rd_sum;
  assign sum_new = s1_r.first ? SUM_W'(s1_r.pixel) : base + SUM_W'(s1_r.pixel);

  // Hold the request while the store is read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= req;
    end
  end

  // Track the last write and hand finished blocks on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      wb_v_r  <= 1'b0;
      blk_v_r <= 1'b0;
    end else begin
      s1_v_r  <= accept;
      wb_v_r  <= s1_v_r;
      blk_v_r <= s1_v_r && s1_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    wb_col_r    <= s1_r.col;
    wb_sum_r    <= sum_new;
    blk_r.sum     <= sum_new;
    blk_r.fac     <= s1_r.fac;
    blk_r.row_end <= s1_r.row_end;
  end

  assign s1_emit = s1_v_r && s1_r.emit;
  assign blk_v   = blk_v_r;
  assign blk     = blk_r;

endmodule

// ===== hw/rtl/bdsa_div.sv =====
module bdsa_div import bdsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic blk_v,
  input  blk_t blk,
  output logic res_v,
  output res_t res
);

  logic [PROD_W-1:0] prod_r;
  logic              prod_v_r;
  logic              row_end_r;
  logic [QUOT_W-1:0] quot;

  // Multiply by the reciprocal of factor squared
  always_ff @(posedge clk) begin
    prod_r    <= PROD_W'(blk.sum) * PROD_W'(recip_of(blk.fac));
    row_end_r <= blk.row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= blk_v;
    end
  end

  // Drop the fraction and clamp to AVG_MAX (254)
  assign quot  = prod_r[PROD_W-1:RECIP_SHIFT];
  assign res_v = prod_v_r;

  always_comb begin
    res.average = (quot > QUOT_W'(AVG_MAX)) ? AVG_W'(AVG_MAX) : quot[AVG_W-1:0];
    res.row_end = row_end_r;
  end

endmodule

// ===== hw/rtl/bdsa_ofifo.sv =====
module bdsa_ofifo import bdsa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  res_t                push_data,
  input  logic                pop,
  output logic                not_empty,
  output res_t                head,
  output logic [OFIFO_CW-1:0] count
);

  res_t                slots [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OFIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OFIFO_CW-1:0] cnt_r, cnt_nxt;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OFIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + OFIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + OFIFO_CW'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - OFIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = cnt_r != '0;
  assign head      = slots[rd_ptr_r];
  assign count     = cnt_r;

endmodule

// ===== hw/rtl/bdsa_checker.sv =====
`include "box_downsample_average_unit_assert.svh"

module bdsa_checker import bdsa_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [PIX_W-1:0]     in_pixel,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [AVG_W-1:0]     out_average,
  input logic                 out_row_end
);

  // Hold a stalled input word
  `BDSA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_pixel), "stalled input word changed")

  // Hold a stalled result word
  `BDSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_average) && $stable(out_row_end), "stalled result word changed")

  // Keep every average inside the clamp range
  `BDSA_ASSERT_SAME(a_avg_range, out_valid, out_average <= AVG_W'(AVG_MAX), "average above clamp limit")

  // Leave reset with an empty result queue
  `BDSA_ASSERT_NEXT_RST(a_rst_empty, !rst_n, !out_valid, "result word present after reset")

  // Leave reset ready for input
  `BDSA_ASSERT_NEXT_RST(a_rst_ready, !rst_n, !in_stall, "input stalled after reset")

endmodule

bind box_downsample_average_unit bdsa_checker u_bdsa_checker (.*);
